@@ design/jipd_pkg.sv @@
// jipd_pkg: shared types, constants and the control program of the joint
// impedance pd controller. No dependencies; used by the top level by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package jipd_pkg;

   // field and datapath widths
   localparam int unsigned JOINT_W    = 3;
   localparam int unsigned DATA_W     = 24;
   localparam int unsigned GAIN_W     = 16;
   localparam int unsigned COEFF_W    = 16;
   localparam int unsigned MUL_A_W    = 17;
   localparam int unsigned MUL_B_W    = 25;
   localparam int unsigned MUL_W      = 42;
   localparam int unsigned ACC_W      = 46;
   localparam int unsigned UPC_W      = 3;
   localparam int unsigned REQ_DATA_W = 112;
   localparam int unsigned RSP_DATA_W = 32;

   // fixed velocity weight 0.99 as 64881/65536
   localparam logic [COEFF_W-1:0] ALPHA_NEW   = 16'd64881;
   localparam logic [COEFF_W-1:0] COEFF_RESET = 16'd328;

   // request kinds carried on tuser
   typedef enum logic [1:0] {
      REQ_SAMPLE   = 2'd0,
      REQ_GAINS    = 2'd1,
      REQ_ACTIVATE = 2'd2,
      REQ_UNUSED   = 2'd3
   } req_kind_type;

   // multiplier operand selects
   typedef enum logic [1:0] {
      MA_COEFF = 2'd0,
      MA_ALPHA = 2'd1,
      MA_STIFF = 2'd2,
      MA_DAMP  = 2'd3
   } mul_a_sel_type;

   typedef enum logic [1:0] {
      MB_GOAL_SP = 2'd0,
      MB_VEL_FV  = 2'd1,
      MB_SP_POS  = 2'd2,
      MB_FV      = 2'd3
   } mul_b_sel_type;

   // accumulator operations
   typedef enum logic [2:0] {
      ACC_NONE    = 3'd0,
      ACC_SP      = 3'd1,
      ACC_FV      = 3'd2,
      ACC_TQ_LOAD = 3'd3,
      ACC_TQ_SUB  = 3'd4
   } acc_op_type;

   // joint state write-back for the short programs
   typedef enum logic [1:0] {
      WR_NONE     = 2'd0,
      WR_GAINS    = 2'd1,
      WR_ACTIVATE = 2'd2
   } wr_op_type;

   // one control word
   typedef struct packed {
      logic          mul_en;
      mul_a_sel_type mul_a;
      mul_b_sel_type mul_b;
      acc_op_type    acc_op;
      wr_op_type     wr_op;
      logic          emit;
      logic          wait_out;
      logic          done;
   } ctl_word_type;

   // program entry points
   localparam logic [UPC_W-1:0] UA_SAMPLE   = 3'd0;
   localparam logic [UPC_W-1:0] UA_GAINS    = 3'd6;
   localparam logic [UPC_W-1:0] UA_ACTIVATE = 3'd7;

   // control store
   function automatic ctl_word_type ucode_rom(input logic [UPC_W-1:0] addr);
      ctl_word_type w;
      w = '{mul_en: 1'b0, mul_a: MA_COEFF, mul_b: MB_GOAL_SP, acc_op: ACC_NONE,
            wr_op: WR_NONE, emit: 1'b0, wait_out: 1'b0, done: 1'b0};
      case (addr)
         3'd0: begin
            // c * (goal - sp)
            w.mul_en = 1'b1; w.mul_a = MA_COEFF; w.mul_b = MB_GOAL_SP;
         end
         3'd1: begin
            // new setpoint, then alpha * (vel - fv)
            w.mul_en = 1'b1; w.mul_a = MA_ALPHA; w.mul_b = MB_VEL_FV;
            w.acc_op = ACC_SP;
         end
         3'd2: begin
            // new filtered velocity, then kp * (sp - pos)
            w.mul_en = 1'b1; w.mul_a = MA_STIFF; w.mul_b = MB_SP_POS;
            w.acc_op = ACC_FV;
         end
         3'd3: begin
            // torque accumulate, then kd * fv
            w.mul_en = 1'b1; w.mul_a = MA_DAMP; w.mul_b = MB_FV;
            w.acc_op = ACC_TQ_LOAD;
         end
         3'd4: begin
            w.acc_op = ACC_TQ_SUB;
         end
         3'd5: begin
            // branch to self while the output slot is full
            w.emit = 1'b1; w.wait_out = 1'b1; w.done = 1'b1;
         end
         3'd6: begin
            w.wr_op = WR_GAINS; w.done = 1'b1;
         end
         3'd7: begin
            w.wr_op = WR_ACTIVATE; w.done = 1'b1;
         end
         default: begin
            w.done = 1'b1;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

@@ design/joint_impedance_pd_control_unit.sv @@
// joint_impedance_pd_control_unit: per-joint impedance pd controller driven by a
// small microprogram over one shared 17x25 multiplier. Depends on jipd_pkg.
`timescale 1ns / 1ps
`default_nettype none

// channel  | direction | carries
// ---------+-----------+------------------------------------------------------
// req_     | in        | request: kind on tuser, joint and operands on tdata
// rsp_     | out       | torque result of a control sample, saturation flag
// csr_     | in        | goal filter coefficient write
//
// A control sample runs six microprogram steps after its transfer, four of
// them on the single shared multiplier. Gain loads and joint activation
// are single-step programs; ignored requests start no program.
// Reset clears all joint state and sets the coefficient to 328; no sweep.
// The result register frees the sequencer; it stalls at its last step only
// while an earlier result is still waiting on rsp_tready.

module joint_impedance_pd_control_unit #(
   parameter int unsigned JOINT_COUNT = 7
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // [2:0] joint, [26:3] position, [50:27] velocity, [74:51] goal,
   // [90:75] stiffness_in, [106:91] damping_in, [111:107] zero
   input  wire logic [111:0] req_tdata,
   // [1:0] req_type
   input  wire logic [1:0]   req_tuser,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // [2:0] out_joint, [26:3] torque, [31:27] zero
   output logic [31:0]       rsp_tdata,
   // [0] saturated
   output logic [0:0]        rsp_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic         csr_wr_en,
   input  wire logic [15:0]  csr_wr_data
);

   localparam int unsigned JIDX_W = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
   localparam logic [4:0]  JOINT_LIMIT = 5'(JOINT_COUNT);
   localparam int unsigned ACC_W = jipd_pkg::ACC_W;
   localparam int unsigned MUL_W = jipd_pkg::MUL_W;
   localparam logic signed [ACC_W-1:0] RND_SP = 46'sd32768;
   localparam logic signed [ACC_W-1:0] RND_TQ = 46'sd524288;

   // joint state
   logic signed [23:0] sp_ff [JOINT_COUNT];
   logic signed [23:0] fv_ff [JOINT_COUNT];
   logic [15:0]        kp_ff [JOINT_COUNT];
   logic [15:0]        kd_ff [JOINT_COUNT];

   // held request
   logic [2:0]         joint_ff;
   logic signed [23:0] pos_ff, vel_ff, goal_ff;
   logic [15:0]        stiff_in_ff, damp_in_ff;

   // sequencer
   logic                               busy_ff, busy_in;
   logic [jipd_pkg::UPC_W-1:0]         upc_ff, upc_in;
   jipd_pkg::ctl_word_type             ctl;
   logic                               hold;
   logic                               out_free;

   // datapath
   logic [15:0]                coeff_ff;
   logic signed [MUL_W-1:0]    prod_ff;
   logic signed [ACC_W-1:0]    acc_ff;
   logic signed [16:0]         mul_a;
   logic signed [24:0]         mul_b;
   logic signed [ACC_W-1:0]    acc_sum;
   logic signed [ACC_W-1:0]    prod_ext;
   logic [JIDX_W+2:0]          jwide;
   logic [JIDX_W-1:0]          jidx;
   logic signed [23:0]         sp_r, fv_r;
   logic [15:0]                kp_r, kd_r;
   logic signed [25:0]         tq_full;
   logic                       tq_sat;
   logic signed [23:0]         tq_val;

   // output slot
   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_joint_ff;
   logic signed [23:0] rsp_torque_ff;
   logic               rsp_sat_ff;

   // request decode
   logic                       req_xfer;
   logic [2:0]                 req_joint;
   logic                       req_joint_ok;
   jipd_pkg::req_kind_type     req_kind;
   logic                       req_start;
   logic [jipd_pkg::UPC_W-1:0] req_entry;

   assign req_joint    = req_tdata[2:0];
   assign req_joint_ok = ({2'b00, req_joint} < JOINT_LIMIT);
   assign req_kind     = jipd_pkg::req_kind_type'(req_tuser);
   assign req_tready   = !busy_ff;
   assign req_xfer     = req_tvalid && req_tready;

   // entry point dispatch on request kind
   always_comb begin
      req_start = 1'b0;
      req_entry = jipd_pkg::UA_SAMPLE;
      case (req_kind)
         jipd_pkg::REQ_SAMPLE: begin
            req_start = req_joint_ok;
            req_entry = jipd_pkg::UA_SAMPLE;
         end
         jipd_pkg::REQ_GAINS: begin
            req_start = req_joint_ok;
            req_entry = jipd_pkg::UA_GAINS;
         end
         jipd_pkg::REQ_ACTIVATE: begin
            req_start = req_joint_ok;
            req_entry = jipd_pkg::UA_ACTIVATE;
         end
         default: begin
            req_start = 1'b0;
         end
      endcase
   end

   // control word and step sequencing
   assign ctl      = jipd_pkg::ucode_rom(upc_ff);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign hold     = ctl.wait_out && !out_free;

   always_comb begin
      busy_in = busy_ff;
      upc_in  = upc_ff;
      if (!busy_ff) begin
         if (req_xfer && req_start) begin
            busy_in = 1'b1;
            upc_in  = req_entry;
         end
      end else if (hold) begin
         upc_in = upc_ff;
      end else if (ctl.done) begin
         busy_in = 1'b0;
      end else begin
         upc_in = upc_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         upc_ff  <= jipd_pkg::UA_SAMPLE;
      end else begin
         busy_ff <= busy_in;
         upc_ff  <= upc_in;
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         joint_ff    <= req_joint;
         pos_ff      <= req_tdata[26:3];
         vel_ff      <= req_tdata[50:27];
         goal_ff     <= req_tdata[74:51];
         stiff_in_ff <= req_tdata[90:75];
         damp_in_ff  <= req_tdata[106:91];
      end
   end

   // coefficient register
   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_ff <= jipd_pkg::COEFF_RESET;
      end else if (csr_wr_en) begin
         coeff_ff <= csr_wr_data;
      end
   end

   // joint state read
   assign jwide = {{JIDX_W{1'b0}}, joint_ff};
   assign jidx  = jwide[JIDX_W-1:0];
   assign sp_r  = sp_ff[jidx];
   assign fv_r  = fv_ff[jidx];
   assign kp_r  = kp_ff[jidx];
   assign kd_r  = kd_ff[jidx];

   // multiplier operands
   always_comb begin
      case (ctl.mul_a)
         jipd_pkg::MA_COEFF: mul_a = {1'b0, coeff_ff};
         jipd_pkg::MA_ALPHA: mul_a = {1'b0, jipd_pkg::ALPHA_NEW};
         jipd_pkg::MA_STIFF: mul_a = {1'b0, kp_r};
         jipd_pkg::MA_DAMP:  mul_a = {1'b0, kd_r};
         default:            mul_a = '0;
      endcase
      case (ctl.mul_b)
         jipd_pkg::MB_GOAL_SP: mul_b = {goal_ff[23], goal_ff} - {sp_r[23], sp_r};
         jipd_pkg::MB_VEL_FV:  mul_b = {vel_ff[23], vel_ff} - {fv_r[23], fv_r};
         jipd_pkg::MB_SP_POS:  mul_b = {sp_r[23], sp_r} - {pos_ff[23], pos_ff};
         jipd_pkg::MB_FV:      mul_b = {fv_r[23], fv_r};
         default:              mul_b = '0;
      endcase
   end

   // shared multiplier, registered product
   always_ff @(posedge clock) begin
      if (busy_ff && ctl.mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
   end

   // accumulator: blends use base*65536 + rounding + product
   assign prod_ext = {{(ACC_W-MUL_W){prod_ff[MUL_W-1]}}, prod_ff};

   always_comb begin
      case (ctl.acc_op)
         jipd_pkg::ACC_SP:
            acc_sum = {{6{sp_r[23]}}, sp_r, 16'd0} + RND_SP + prod_ext;
         jipd_pkg::ACC_FV:
            acc_sum = {{6{fv_r[23]}}, fv_r, 16'd0} + RND_SP + prod_ext;
         jipd_pkg::ACC_TQ_LOAD:
            acc_sum = {{(ACC_W-MUL_W-2){prod_ff[MUL_W-1]}}, prod_ff, 2'b00} + RND_TQ;
         jipd_pkg::ACC_TQ_SUB:
            acc_sum = acc_ff - prod_ext;
         default:
            acc_sum = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (busy_ff && (ctl.acc_op == jipd_pkg::ACC_TQ_LOAD ||
                      ctl.acc_op == jipd_pkg::ACC_TQ_SUB)) begin
         acc_ff <= acc_sum;
      end
   end

   // joint state write-back
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < JOINT_COUNT; i++) begin
            sp_ff[i] <= '0;
            fv_ff[i] <= '0;
            kp_ff[i] <= '0;
            kd_ff[i] <= '0;
         end
      end else if (busy_ff) begin
         if (ctl.acc_op == jipd_pkg::ACC_SP) begin
            sp_ff[jidx] <= acc_sum[39:16];
         end
         if (ctl.acc_op == jipd_pkg::ACC_FV) begin
            fv_ff[jidx] <= acc_sum[39:16];
         end
         case (ctl.wr_op)
            jipd_pkg::WR_GAINS: begin
               kp_ff[jidx] <= stiff_in_ff;
               kd_ff[jidx] <= damp_in_ff;
            end
            jipd_pkg::WR_ACTIVATE: begin
               sp_ff[jidx] <= pos_ff;
               fv_ff[jidx] <= '0;
            end
            default: begin
            end
         endcase
      end
   end

   // torque rounding and clipping
   assign tq_full = acc_ff[ACC_W-1:20];
   assign tq_sat  = !((tq_full[25:23] == 3'b000) || (tq_full[25:23] == 3'b111));
   assign tq_val  = !tq_sat ? tq_full[23:0] :
                    (tq_full[25] ? 24'sh800000 : 24'sh7FFFFF);

   // result slot
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (busy_ff && ctl.emit && !hold) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff && ctl.emit && !hold) begin
         rsp_joint_ff  <= joint_ff;
         rsp_torque_ff <= tq_val;
         rsp_sat_ff    <= tq_sat;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_torque_ff, rsp_joint_ff};
   assign rsp_tuser  = rsp_sat_ff;

`ifndef SYNTHESIS
   // a valid control sample starts the program at its entry
   a_sample_starts: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_joint_ok && req_kind == jipd_pkg::REQ_SAMPLE
      |=> busy_ff && upc_ff == jipd_pkg::UA_SAMPLE)
      else $error("control sample did not start the program");

   // the emit step lands a result in the slot
   a_emit_fills: assert property (@(posedge clock) disable iff (reset)
      busy_ff && ctl.emit && out_free |=> rsp_valid_ff && !busy_ff)
      else $error("emit step did not deliver a result");

   // a clipped torque sits at one of the range ends
   a_sat_clips: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_sat_ff
      |-> rsp_torque_ff == 24'sh7FFFFF || rsp_torque_ff == 24'sh800000)
      else $error("saturation flag without a clipped torque");

   // while the slot is blocked the sequencer holds at the emit step
   a_hold_step: assert property (@(posedge clock) disable iff (reset)
      busy_ff && hold |=> busy_ff && $stable(upc_ff))
      else $error("sequencer moved while the result slot was full");
`endif

endmodule

`default_nettype wire

@@ dv/tb_joint_impedance_pd_control_unit.sv @@
`timescale 1ns / 1ps
// tb_joint_impedance_pd_control_unit: self-checking testbench for the joint impedance
// pd controller; predicts every torque transfer and compares it field by field.
// Depends on jipd_pkg and joint_impedance_pd_control_unit.

module tb_joint_impedance_pd_control_unit;

   localparam int unsigned JOINT_COUNT  = 7;
   localparam int          QUIET_LIMIT  = 4000;
   localparam int          DRAIN_CYCLES = 16;
   localparam int          MAX_REPORTS  = 10;
   localparam int          PHASE_ITEMS  = 390;
   localparam int          DRAIN_EVERY  = 150;
   localparam longint      ALPHA_OLD    = 655;
   localparam longint      TORQUE_MAX   = 8388607;
   localparam longint      TORQUE_MIN   = -8388608;
   localparam logic signed [23:0] Q_MAX = 24'sh7FFFFF;
   localparam logic signed [23:0] Q_MIN = 24'sh800000;

   // request word, first field in the lowest bits
   typedef struct packed {
      logic [4:0]         pad;
      logic [15:0]        damping_in;
      logic [15:0]        stiffness_in;
      logic signed [23:0] goal;
      logic signed [23:0] velocity;
      logic signed [23:0] position;
      logic [2:0]         joint;
   } joint_request_type;

   typedef struct packed {
      logic [4:0]         pad;
      logic signed [23:0] torque;
      logic [2:0]         joint;
   } torque_word_type;

   typedef struct {
      logic [2:0]         joint;
      logic signed [23:0] torque;
      logic               saturated;
   } torque_result_type;

   logic         clock = 1'b0;
   logic         reset;
   logic [111:0] req_tdata;
   logic [1:0]   req_tuser;
   logic         req_tvalid;
   logic         req_tready;
   logic [31:0]  rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic         csr_wr_en;
   logic [15:0]  csr_wr_data;

   // predicted joint state and filter coefficient
   logic signed [23:0] setpoint_state [JOINT_COUNT];
   logic signed [23:0] velocity_state [JOINT_COUNT];
   logic [15:0]        stiffness_state [JOINT_COUNT];
   logic [15:0]        damping_state [JOINT_COUNT];
   logic [15:0]        goal_coeff;

   torque_result_type pending_torques[$];
   int mismatch_count = 0;
   int quiet_cycles   = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   joint_impedance_pd_control_unit #(
      .JOINT_COUNT(JOINT_COUNT)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #4 clock = ~clock;

   // update joint state for one accepted request and queue its torque
   function automatic void predict_joint_item(input jipd_pkg::req_kind_type kind,
                                              input joint_request_type req);
      longint            c;
      longint            acc;
      longint            tq;
      int                j;
      torque_result_type res;
      j = int'(req.joint);
      if (j < JOINT_COUNT) begin
         case (kind)
            jipd_pkg::REQ_GAINS: begin
               stiffness_state[j] = req.stiffness_in;
               damping_state[j]   = req.damping_in;
            end
            jipd_pkg::REQ_ACTIVATE: begin
               setpoint_state[j] = req.position;
               velocity_state[j] = '0;
            end
            jipd_pkg::REQ_SAMPLE: begin
               c   = longint'(goal_coeff);
               acc = c * longint'(req.goal) + (65536 - c) * longint'(setpoint_state[j])
                     + 32768;
               setpoint_state[j] = 24'(acc >>> 16);
               acc = ALPHA_OLD * longint'(velocity_state[j])
                     + longint'(jipd_pkg::ALPHA_NEW) * longint'(req.velocity) + 32768;
               velocity_state[j] = 24'(acc >>> 16);
               acc = longint'(stiffness_state[j])
                     * (longint'(setpoint_state[j]) - longint'(req.position)) * 4
                     - longint'(damping_state[j]) * longint'(velocity_state[j]);
               tq = (acc + 524288) >>> 20;
               res.saturated = 1'b0;
               if (tq > TORQUE_MAX) begin
                  tq = TORQUE_MAX;
                  res.saturated = 1'b1;
               end else if (tq < TORQUE_MIN) begin
                  tq = TORQUE_MIN;
                  res.saturated = 1'b1;
               end
               res.joint  = req.joint;
               res.torque = 24'(tq);
               pending_torques.insert(pending_torques.size(), res);
            end
            default: begin
            end
         endcase
      end
   endfunction

   function automatic void report_mismatch(input string field, input longint want,
                                           input longint got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("mismatch on %s at %0t: expected %0d, got %0d", field, $realtime, want, got);
   endfunction

   // compare each result transfer with the oldest pending torque
   always @(posedge clock) begin : check_torque
      torque_word_type   got;
      torque_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_torques.size() == 0) begin
            report_mismatch("unrequested torque", 0, got.torque);
         end else begin
            want = pending_torques.pop_front();
            if (got.joint !== want.joint)
               report_mismatch("joint", want.joint, got.joint);
            if (got.torque !== want.torque)
               report_mismatch("torque", want.torque, got.torque);
            if (rsp_tuser[0] !== want.saturated)
               report_mismatch("saturated", want.saturated, rsp_tuser[0]);
         end
      end
   end

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // watchdog on cycles with no transfer at all
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("joint_impedance_pd_control_unit regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // one request transfer, with random idle cycles ahead of it
   task automatic send_req(input jipd_pkg::req_kind_type kind, input logic [2:0] joint,
                           input logic signed [23:0] pos, input logic signed [23:0] vel,
                           input logic signed [23:0] tgt, input logic [15:0] kp,
                           input logic [15:0] kd);
      joint_request_type req;
      req = '{pad: '0, damping_in: kd, stiffness_in: kp, goal: tgt, velocity: vel,
              position: pos, joint: joint};
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tdata  <= req;
      req_tuser  <= kind;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_joint_item(kind, req);
      @(negedge clock);
   endtask

   // hold off the sender until every torque is back and the sequencer is free
   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      while (pending_torques.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_goal_coeff(input logic [15:0] value);
      wait_quiet();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en  <= 1'b0;
      goal_coeff = value;
   endtask

   function automatic logic signed [23:0] rand_q420();
      case ($urandom_range(0, 7))
         0: return 24'($urandom);
         1: begin
            case ($urandom_range(0, 3))
               0: return Q_MIN;
               1: return Q_MAX;
               2: return '0;
               default: return '1;
            endcase
         end
         default: return 24'($urandom_range(0, 2097151) - 1048576);
      endcase
   endfunction

   function automatic logic [15:0] rand_gain();
      case ($urandom_range(0, 5))
         0: return 16'($urandom);
         1: return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
         default: return 16'($urandom_range(0, 2047));
      endcase
   endfunction

   // mostly samples on in-range joints, some gain loads and activations, a little noise
   task automatic send_random_item(output bit counted);
      jipd_pkg::req_kind_type kind;
      logic [2:0]             joint;
      int                     pick;
      pick = $urandom_range(0, 99);
      if (pick < 70)
         kind = jipd_pkg::REQ_SAMPLE;
      else if (pick < 83)
         kind = jipd_pkg::REQ_GAINS;
      else if (pick < 95)
         kind = jipd_pkg::REQ_ACTIVATE;
      else
         kind = jipd_pkg::REQ_UNUSED;
      joint = ($urandom_range(0, 99) < 5) ? 3'd7 : 3'($urandom_range(0, JOINT_COUNT - 1));
      counted = (kind != jipd_pkg::REQ_UNUSED) && (joint < JOINT_COUNT);
      send_req(kind, joint, rand_q420(), rand_q420(), rand_q420(), rand_gain(), rand_gain());
   endtask

   // field extremes, every request kind and the ignored cases
   task automatic test_directed();
      send_req(jipd_pkg::REQ_SAMPLE,   3'd0, '0,    '0,    '0,    '0,       '0);
      send_req(jipd_pkg::REQ_GAINS,    3'd0, '0,    '0,    '0,    16'hFFFF, 16'hFFFF);
      send_req(jipd_pkg::REQ_ACTIVATE, 3'd0, Q_MIN, '0,    '0,    '0,       '0);
      send_req(jipd_pkg::REQ_SAMPLE,   3'd0, Q_MAX, Q_MIN, Q_MAX, '0,       '0);
      send_req(jipd_pkg::REQ_SAMPLE,   3'd0, Q_MIN, Q_MAX, Q_MIN, '0,       '0);
      send_req(jipd_pkg::REQ_SAMPLE,   3'd0, Q_MAX, Q_MAX, Q_MIN, '0,       '0);
      send_req(jipd_pkg::REQ_GAINS,    3'd6, '0,    '0,    '0,    16'd1,    '0);
      send_req(jipd_pkg::REQ_ACTIVATE, 3'd6, Q_MAX, '0,    '0,    '0,       '0);
      send_req(jipd_pkg::REQ_SAMPLE,   3'd6, '0,    '0,    Q_MAX, '0,       '0);
      send_req(jipd_pkg::REQ_GAINS,    3'd3, '0,    '0,    '0,    '0,       16'hFFFF);
      send_req(jipd_pkg::REQ_SAMPLE,   3'd3, '0,    Q_MAX, '0,    '0,       '0);
      send_req(jipd_pkg::REQ_SAMPLE,   3'd3, '0,    Q_MIN, '0,    '0,       '0);
      // joint out of range and unused kind: no torque, no state change
      send_req(jipd_pkg::REQ_SAMPLE,   3'd7, Q_MAX, Q_MAX, Q_MAX, '0,       '0);
      send_req(jipd_pkg::REQ_GAINS,    3'd7, '0,    '0,    '0,    16'h1234, 16'h5678);
      send_req(jipd_pkg::REQ_ACTIVATE, 3'd7, Q_MAX, '0,    '0,    '0,       '0);
      send_req(jipd_pkg::REQ_UNUSED,   3'd0, Q_MAX, Q_MAX, Q_MAX, 16'hFFFF, 16'hFFFF);
      send_req(jipd_pkg::REQ_SAMPLE,   3'd0, '0,    '0,    '0,    '0,       '0);
      // re-activation clears the filtered velocity
      send_req(jipd_pkg::REQ_ACTIVATE, 3'd0, '0,    '0,    '0,    '0,       '0);
      send_req(jipd_pkg::REQ_SAMPLE,   3'd0, '0,    '0,    '0,    '0,       '0);
      send_req(jipd_pkg::REQ_GAINS,    3'd5, '0,    '0,    '0,    16'h8001, 16'h7FFE);
      send_req(jipd_pkg::REQ_SAMPLE,   3'd5, 24'sh0AAAAA, 24'sh555555, 24'shF0F0F0, '0, '0);
   endtask

   // goal filter at both ends of its range
   task automatic test_goal_filter_settings();
      write_goal_coeff(16'h0000);
      send_req(jipd_pkg::REQ_GAINS,    3'd1, '0,    '0,    '0,    16'h0400, 16'h0100);
      send_req(jipd_pkg::REQ_ACTIVATE, 3'd1, '0,    '0,    '0,    '0,       '0);
      send_req(jipd_pkg::REQ_SAMPLE,   3'd1, '0,    '0,    Q_MAX, '0,       '0);
      send_req(jipd_pkg::REQ_SAMPLE,   3'd1, '0,    '0,    Q_MIN, '0,       '0);
      write_goal_coeff(16'hFFFF);
      send_req(jipd_pkg::REQ_SAMPLE,   3'd1, '0,    '0,    Q_MAX, '0,       '0);
      send_req(jipd_pkg::REQ_SAMPLE,   3'd1, '0,    '0,    Q_MIN, '0,       '0);
      send_req(jipd_pkg::REQ_SAMPLE,   3'd1, Q_MIN, Q_MAX, Q_MAX, '0,       '0);
   endtask

   // random traffic under one idling pattern and one coefficient
   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input logic [15:0] coeff);
      int count;
      bit counted;
      write_goal_coeff(coeff);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      count = 0;
      while (count < PHASE_ITEMS) begin
         send_random_item(counted);
         if (counted) begin
            count++;
            // sender pause until every torque has come back
            if (count % DRAIN_EVERY == 0) wait_quiet();
         end
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_tdata   = '0;
      req_tuser   = jipd_pkg::REQ_SAMPLE;
      req_tvalid  = 1'b0;
      rsp_tready  = 1'b0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      goal_coeff  = jipd_pkg::COEFF_RESET;
      for (int j = 0; j < JOINT_COUNT; j++) begin
         setpoint_state[j]  = '0;
         velocity_state[j]  = '0;
         stiffness_state[j] = '0;
         damping_state[j]   = '0;
      end
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_goal_filter_settings();
      test_random_traffic(0, 0, 16'hFFFF);
      test_random_traffic(79, 0, 16'h0000);
      test_random_traffic(0, 79, 16'($urandom_range(0, 65535)));
      test_random_traffic(38, 38, jipd_pkg::COEFF_RESET);

      wait_quiet();
      mismatch_count += pending_torques.size();
      if (mismatch_count == 0)
         $display("joint_impedance_pd_control_unit regression: pass");
      else
         $display("joint_impedance_pd_control_unit regression: fail");
      $finish;
   end

endmodule
